[src/spq_pkg.sv]
package spq_pkg;

   localparam int PRIO_W = 31;
   localparam int TAG_W  = 16;
   localparam int OCC_W  = 5;
   localparam int HEAD_W = 32;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [HEAD_W-1:0] HEAD_NONE = '1;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctrl_type;

endpackage

[src/stable_priority_queue.sv]
// Bounded priority queue held as a row of CAPACITY sorted cells.
// Request channel (req_): req_command selects enqueue or dequeue; an enqueue
// carries req_priority_req and req_payload. A transfer happens at a rising
// edge with req_valid high and req_stall low.
// Response channel (rsp_): one response per request, registered, presented
// in the cycle after the request transfer. It carries the removed tag, a status
// code, the occupancy, an empty flag and the head priority (-1 when empty).
// Each cell compares its entry with the incoming priority and takes the new
// entry, its left neighbour's or its right neighbour's in the same cycle, so
// one request is taken every cycle while req_stall is low, set by the single
// compare-and-shift step of the cell row.
// An enqueue into a full queue is dropped with status 2; a dequeue on an
// empty queue reports status 1 and a zero tag.
// Reset is synchronous and empties the queue; slot contents are not cleared,
// as only occupied slots are ever read.
// While the receiver stalls, the response holds and req_stall is raised, so
// no request is taken until the waiting response has been transferred.
module stable_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic [spq_pkg::PRIO_W-1:0]         req_priority_req,
   input  logic [spq_pkg::TAG_W-1:0]          req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [spq_pkg::TAG_W-1:0]          rsp_payload_out,
   output logic [1:0]                         rsp_status,
   output logic [spq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_is_empty,
   output logic signed [spq_pkg::HEAD_W-1:0]  rsp_head_priority
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                      rsp_valid_ff;
   logic [TAG_W-1:0]          rsp_payload_out_ff;
   logic [1:0]                rsp_status_ff;
   logic [OCC_W-1:0]          rsp_occupancy_ff;
   logic                      rsp_is_empty_ff;
   logic signed [HEAD_W-1:0]  rsp_head_priority_ff;

   logic          accept;
   logic          full;
   logic          empty;
   cell_ctrl_type ctrl;
   entry_type     new_entry;
   logic [1:0]    status;
   logic [TAG_W-1:0] removed_tag;
   logic [CNT_W+OCC_W-1:0] count_ext;

   logic      gt         [CAPACITY];
   entry_type entry      [CAPACITY];
   entry_type entry_next [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff >= CNT_W'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign new_entry = '{prio: req_priority_req, tag: req_payload};

   assign ctrl.insert = accept && (req_command == CMD_ENQUEUE) && !full;
   assign ctrl.remove = accept && (req_command == CMD_DEQUEUE) && !empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CNT_W'(i)),
         .new_entry   (new_entry),
         .left_gt     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
         .left_entry  (entry[(i == 0) ? 0 : i - 1]),
         .right_entry (entry[(i == CAPACITY - 1) ? i : i + 1]),
         .gt          (gt[i]),
         .entry       (entry[i]),
         .entry_next  (entry_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      status      = STATUS_DONE;
      removed_tag = '0;
      if (req_command == CMD_ENQUEUE) begin
         if (full) begin
            status = STATUS_FULL;
         end
      end else if (empty) begin
         status = STATUS_EMPTY;
      end else begin
         removed_tag = entry[0].tag;
      end
   end

   assign count_ext = {{OCC_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_out_ff <= removed_tag;
         rsp_status_ff      <= status;
         rsp_occupancy_ff   <= count_ext[OCC_W-1:0];
         rsp_is_empty_ff    <= (count_in == '0);
         if (count_in == '0) begin
            rsp_head_priority_ff <= HEAD_NONE;
         end else begin
            rsp_head_priority_ff <= {1'b0, entry_next[0].prio};
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_out   = rsp_payload_out_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_occupancy     = rsp_occupancy_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;
   assign rsp_head_priority = rsp_head_priority_ff;

endmodule

[src/spq_cell.sv]
module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  spq_pkg::entry_type    new_entry,
   input  logic                  left_gt,
   input  spq_pkg::entry_type    left_entry,
   input  spq_pkg::entry_type    right_entry,
   output logic                  gt,
   output spq_pkg::entry_type    entry,
   output spq_pkg::entry_type    entry_next
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // The incoming entry goes in front of this one only when this slot is free
   // or holds a strictly larger priority, which keeps equal priorities in order.
   assign gt = !(occupied && (entry_ff.prio <= new_entry.prio));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (gt) begin
            entry_in = left_gt ? left_entry : new_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

[src/spq_checker.sv]
module spq_assertions (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [spq_pkg::TAG_W-1:0]          rsp_payload_out,
   input logic [1:0]                         rsp_status,
   input logic [spq_pkg::OCC_W-1:0]          rsp_occupancy,
   input logic                               rsp_is_empty,
   input logic signed [spq_pkg::HEAD_W-1:0]  rsp_head_priority
);
   import spq_pkg::*;

   // Every request transfer produces a response in the following cycle.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request transfer without a response");

   // An empty queue reports no head and no entries.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |->
         (rsp_head_priority == HEAD_NONE) && (rsp_occupancy == '0))
      else $error("empty queue reports a head or entries");

   // A dequeue on an empty queue removes nothing and leaves the queue empty.
   a_deq_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |->
         rsp_is_empty && (rsp_payload_out == '0))
      else $error("dequeue on empty queue returned a tag");

   // A non-empty queue always has a non-negative head priority.
   a_head_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_empty) |-> !rsp_head_priority[HEAD_W-1])
      else $error("occupied queue reports a negative head");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_payload_out)
         && $stable(rsp_status) && $stable(rsp_head_priority))
      else $error("stalled response changed");

endmodule

bind stable_priority_queue spq_assertions u_spq_assertions (.*);
